>>> design/timer_expiry_queue_assert.svh
// Assertion macros shared by the checker.
`ifndef TIMER_EXPIRY_QUEUE_ASSERT_SVH
`define TIMER_EXPIRY_QUEUE_ASSERT_SVH
// Implication checked every clock, off while in reset.
`define TEQ_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define TEQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> design/teq_pkg.sv
package teq_pkg;
    localparam int CAPACITY = 16;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int MAX_RESULTS = 16;
    localparam int QDEPTH = 2;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_RUN = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_DEL = 2'd1;
    localparam logic [1:0] KIND_EXP = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  req;
        logic [63:0] now;
        logic [31:0] delay;
        logic [31:0] handle;
        logic [31:0] target;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] id;
        logic [31:0] handle;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EMIT, S_WAIT
    } t_state;
endpackage

>>> design/teq_front.sv
// Accepts requests, drops unused codes, precomputes expiry, queues commands.
module teq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  teq_pkg::t_cmd  i_cmd,
    output logic           o_cvalid,
    output teq_pkg::t_cmd  o_cmd,
    input  logic           i_ctake
);
    import teq_pkg::*;
    t_cmd r_q [QDEPTH];
    logic [$clog2(QDEPTH):0] r_cnt;
    logic [$clog2(QDEPTH)-1:0] r_wp, r_rp;
    logic w_wr, w_rd;
    t_cmd w_c;

    assign o_full = (r_cnt == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign w_wr = i_push && !o_full && (i_cmd.req != REQ_UNUSED);
    assign w_rd = i_ctake && o_cvalid;
    assign o_cvalid = (r_cnt != '0);
    assign o_cmd = r_q[r_rp];

    always_comb begin
        w_c = i_cmd;
        // an add carries its expiry in the now field
        if (i_cmd.req == REQ_ADD) w_c.now = i_cmd.now + {32'd0, i_cmd.delay};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= '0; r_rp <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + w_wr - w_rd;
        end
        if (w_wr) r_q[r_wp] <= w_c;
    end
endmodule

>>> design/teq_back.sv
// Executes delete and run commands by scanning the table one slot per cycle; an add takes the lowest free slot.
module teq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cvalid,
    input  teq_pkg::t_cmd  i_cmd,
    output logic           o_ctake,
    output logic           o_rvalid,
    output teq_pkg::t_res  o_res,
    input  logic           i_rtake
);
    import teq_pkg::*;
    logic [CAPACITY-1:0] r_valid;
    logic [63:0] r_exp [CAPACITY];
    logic [31:0] r_id  [CAPACITY];
    logic [31:0] r_hdl [CAPACITY];
    logic [31:0] r_ctr;
    t_state r_st, n_st;
    t_cmd r_cmd;
    logic [IDX_W:0] r_i;
    logic r_found;
    logic [IDX_W-1:0] r_best;
    logic [63:0] r_bexp;
    logic [31:0] r_bid;
    logic [4:0] r_n;
    logic [IDX_W:0] r_ccnt;
    logic r_rv;
    t_res r_res;

    logic [IDX_W-1:0] w_i;
    logic w_cand, w_better, w_done, w_full, w_add_ok;
    logic [31:0] w_nid;
    logic [IDX_W-1:0] w_free;
    logic [1:0] w_add_st;

    assign w_i = r_i[IDX_W-1:0];
    assign w_done = (r_i == (IDX_W+1)'(CAPACITY - 1));
    assign w_full = &r_valid;
    assign w_nid = (r_ctr + 32'd1 == 32'd0) ? 32'd1 : r_ctr + 32'd1;
    assign w_cand = r_valid[w_i] && (r_exp[w_i] < r_cmd.now);
    assign w_better = !r_found || (r_exp[w_i] < r_bexp) ||
                      (r_exp[w_i] == r_bexp && r_id[w_i] < r_bid);
    assign w_add_ok = (i_cmd.handle != 32'd0) && !w_full;
    assign w_add_st = (i_cmd.handle == 32'd0) ? ST_ZERO : (w_full ? ST_FULL : ST_OK);
    assign o_rvalid = r_rv;
    assign o_res = r_res;

    // lowest free slot
    always_comb begin
        w_free = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
            if (!r_valid[k]) w_free = IDX_W'(k);
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_cvalid) n_st = (i_cmd.req == REQ_ADD) ? S_WAIT : S_SCAN;
            S_SCAN: if (w_done) n_st = S_EMIT;
            S_EMIT: n_st = S_WAIT;
            S_WAIT: if (!r_rv || i_rtake) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_WAIT && (!r_rv || i_rtake) && r_cmd.req == REQ_RUN && !r_res.last)
            n_st = S_SCAN;
    end

    always_comb begin
        o_ctake = (r_st == S_IDLE) && i_cvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_valid <= '0; r_ctr <= '0; r_rv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_rv && i_rtake) r_rv <= 1'b0;
            case (r_st)
                S_IDLE: if (i_cvalid) begin
                    r_cmd <= i_cmd; r_i <= '0; r_n <= '0; r_ccnt <= '0;
                    if (i_cmd.req == REQ_ADD) begin
                        r_rv <= 1'b1;
                        r_res <= '{KIND_ADD, w_add_st, (w_add_ok ? w_nid : 32'd0),
                                   32'd0, 1'b1};
                        r_found <= w_add_ok;
                        r_best <= w_free;
                        if (w_add_ok) r_ctr <= w_nid;
                    end else begin
                        r_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_cmd.req == REQ_DEL) begin
                        if (!r_found && r_valid[w_i] && r_id[w_i] == r_cmd.target) begin
                            r_found <= 1'b1; r_best <= w_i;
                        end
                    end else if (w_cand) begin
                        r_ccnt <= r_ccnt + 1'b1;
                        if (w_better) begin
                            r_found <= 1'b1; r_best <= w_i;
                            r_bexp <= r_exp[w_i]; r_bid <= r_id[w_i];
                        end
                    end
                    r_i <= r_i + 1'b1;
                end
                S_EMIT: begin
                    r_rv <= 1'b1;
                    if (r_cmd.req == REQ_DEL) begin
                        if (r_found) r_valid[r_best] <= 1'b0;
                        r_res <= '{KIND_DEL, ST_OK, r_cmd.target, 32'd0, 1'b1};
                    end else if (r_found) begin
                        r_valid[r_best] <= 1'b0;
                        // last when the run limit is hit or no other timer has expired
                        r_res <= '{KIND_EXP, ST_OK, r_id[r_best], r_hdl[r_best],
                                   (r_n == 5'(MAX_RESULTS - 1)) ||
                                   (r_ccnt == (IDX_W+1)'(1))};
                        r_n <= r_n + 1'b1;
                    end else begin
                        r_res <= '{KIND_NONE, ST_OK, 32'd0, 32'd0, 1'b1};
                    end
                end
                S_WAIT: begin
                    if ((!r_rv || i_rtake) && r_cmd.req == REQ_ADD && r_found) begin
                        r_valid[r_best] <= 1'b1; r_found <= 1'b0;
                    end
                    if (n_st == S_SCAN) begin
                        r_i <= '0; r_found <= 1'b0; r_ccnt <= '0;
                    end
                end
                default: ;
            endcase
        end
        if (r_st == S_WAIT && r_cmd.req == REQ_ADD && r_found) begin
            r_exp[r_best] <= r_cmd.now;
            r_id[r_best]  <= r_ctr;
            r_hdl[r_best] <= r_cmd.handle;
        end
    end
endmodule

>>> design/timer_expiry_queue.sv
// Timer table with add/delete/run requests, queue-style handshakes.
// An add is answered directly; delete and run scan every slot of the table
// before their result, and each further expired timer needs a new scan after a pop.
// The back end takes no new command until its last result is popped; a
// 2-deep queue decouples intake from the slot scan. Reset (i_rst_n low, sync)
// empties the table and queues and zeros the id counter.
module timer_expiry_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_now,
    input  logic [31:0] i_delay,
    input  logic [31:0] i_owner_handle,
    input  logic [31:0] i_target_id,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_id,
    output logic [31:0] o_out_handle,
    output logic        o_last
);
    import teq_pkg::*;
    t_cmd w_in, w_cmd;
    t_res w_res;
    logic w_cv, w_ct, w_rv;

    assign w_in = '{i_req_type, i_now, i_delay, i_owner_handle, i_target_id};

    teq_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_cmd(w_in),
        .o_cvalid(w_cv), .o_cmd(w_cmd), .i_ctake(w_ct)
    );

    // result register holds one transaction until it is popped; the back end stalls meanwhile
    teq_back u_back (
        .i_clk, .i_rst_n, .i_cvalid(w_cv), .i_cmd(w_cmd), .o_ctake(w_ct),
        .o_rvalid(w_rv), .o_res(w_res), .i_rtake(i_pop)
    );

    assign o_empty = !w_rv;
    assign o_result_kind = w_res.kind;
    assign o_status = w_res.status;
    assign o_out_id = w_res.id;
    assign o_out_handle = w_res.handle;
    assign o_last = w_res.last;
endmodule

>>> design/teq_checker.sv
module teq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [1:0]  o_result_kind,
    input logic [1:0]  o_status,
    input logic [31:0] o_out_id,
    input logic [31:0] o_out_handle,
    input logic        o_last
);
    import teq_pkg::*;
`include "timer_expiry_queue_assert.svh"
    `TEQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_out_id))
    `TEQ_ASSERT_IMPL(a_ack_last, i_clk, i_rst_n, !o_empty && o_result_kind != KIND_EXP, o_last)
    `TEQ_ASSERT_IMPL(a_stat, i_clk, i_rst_n, !o_empty && o_status != ST_OK, o_out_id == '0)
    `TEQ_ASSERT_IMPL(a_hdl, i_clk, i_rst_n, !o_empty && o_result_kind != KIND_EXP, o_out_handle == '0)
endmodule

bind timer_expiry_queue teq_checker u_chk (.*);
